>>> sv/slap_pkg.sv
`default_nettype none
package slap_pkg;

   localparam int unsigned SAMPLE_W    = 32;
   localparam int unsigned COEF_W      = 16;
   localparam int unsigned SLOT_W      = 5;
   localparam int unsigned POS_W       = 6;
   localparam int unsigned DEF_MAX_TAPS = 32;

   localparam logic [4:0] TAP_COPY        = 5'h00;
   localparam logic [4:0] TAP_FIRST_ORDER = 5'h1f;
   localparam logic [POS_W-1:0] POS_SAT   = 6'd63;

   localparam logic [4:0] TAP_RESET  = 5'd4;
   localparam logic [3:0] Q_RESET    = 4'd9;
   localparam logic [5:0] BITS_RESET = 6'd16;

   typedef enum logic [1:0] {
      CSR_TAP_COUNT   = 2'd0,
      CSR_QUANT_SHIFT = 2'd1,
      CSR_SAMPLE_BITS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_FWD,
      CELL_BWD,
      CELL_SHIFT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [SLOT_W-1:0]        index;
      logic [COEF_W-1:0]        value;
   } cell_ctrl_type;

   // sign extend from bit (bits-1); widths of 32 and up pass through
   function automatic logic [SAMPLE_W-1:0] sext_bits(input logic [SAMPLE_W-1:0] v,
                                                     input logic [5:0] bits);
      logic [5:0] b;
      logic [5:0] sh;
      logic [SAMPLE_W-1:0] t;
      begin
         b  = (bits == 6'd0) ? 6'd1 : bits;
         sh = 6'd32 - b;
         t  = v << sh;
         if (bits >= 6'd32) begin
            sext_bits = v;
         end else begin
            sext_bits = SAMPLE_W'($signed(t) >>> sh);
         end
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] asr32(input logic [SAMPLE_W-1:0] v,
                                                 input logic [3:0] s);
      asr32 = SAMPLE_W'($signed(v) >>> s);
   endfunction

endpackage
`default_nettype wire

>>> sv/slap_if.sv
`default_nettype none
interface slap_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic               frame_start;
   logic [4:0]         coef_index;
   logic signed [15:0] coef_value;
   logic signed [31:0] residual;
   modport source (output valid, action, frame_start, coef_index, coef_value, residual,
                   input ready);
   modport sink   (input valid, action, frame_start, coef_index, coef_value, residual,
                   output ready);
endinterface

interface slap_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

interface slap_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [5:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/sign_lms_adaptive_predictor_core.sv
`default_nettype none
// Sign-LMS predictor for lossless audio. History and coefficients live in a ring of
// MAX_TAPS cells. A load item writes one coefficient. A copied, first-order or warm-up
// sample goes straight to the final step. For a predicted sample the ring first
// rotates once forward past one multiply-accumulate unit, then once backward past the
// sign-adaptation unit, then shifts the new sample in. A result held on the output
// delays only the final step.
module sign_lms_adaptive_predictor_core #(
   parameter int unsigned MAX_TAPS = slap_pkg::DEF_MAX_TAPS
) (
   input  logic       clock,
   input  logic       reset,
   slap_req_if.sink   req_if,
   slap_rsp_if.source rsp_if,
   slap_csr_if.sink   csr_if
);
   import slap_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_TAPS);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_TAPS - 1);

   typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_ADAPT, ST_DONE} state_type;

   state_type state_ff;
   logic [4:0] tap_ff;
   logic [3:0] q_ff;
   logic [5:0] bits_ff;
   logic [POS_W-1:0] pos_ff;
   logic [IDX_W-1:0] n_ff, t_ff;
   logic [SAMPLE_W-1:0] base_ff, acc_ff, prod_ff, resid_ff, err_ff, samp_ff;
   logic sign_ff;
   logic rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff;

   logic [SAMPLE_W-1:0] hist_w [MAX_TAPS];
   logic [COEF_W-1:0]   coef_w [MAX_TAPS];
   cell_ctrl_type ctrl;
   logic [SAMPLE_W-1:0] head_hist;
   logic [COEF_W-1:0]   head_coef;

   logic accept, done_fire;
   logic [IDX_W-1:0] n_cfg;
   logic [SAMPLE_W-1:0] h0, hl, first_sum, round_term;
   logic [SAMPLE_W-1:0] diff, prod_in, sum_all, pred_out;
   logic [SAMPLE_W+COEF_W-1:0] prod_full;
   logic [IDX_W-1:0] k_idx, step;
   logic stop, active, dneg, upd;
   logic [SAMPLE_W-1:0] d, mag, shifted, err_next;
   logic [SAMPLE_W+IDX_W-1:0] sub_full;
   logic [COEF_W-1:0] coef_adj;

   assign accept    = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;

   assign n_cfg = ({1'b0, tap_ff} > 6'(MAX_TAPS - 1)) ? LAST : IDX_W'(tap_ff);
   assign h0 = hist_w[0];
   assign hl = hist_w[MAX_TAPS-1];
   assign first_sum  = sext_bits(h0 + SAMPLE_W'(req_if.residual), bits_ff);
   assign round_term = (q_ff != 4'd0) ? (SAMPLE_W'(1) << (q_ff - 4'd1)) : '0;

   // forward pass: cell 0 holds slot t_ff
   assign diff      = h0 - base_ff;
   assign prod_full = ($signed(diff) * $signed(coef_w[0]));
   assign prod_in   = (t_ff < n_ff) ? prod_full[SAMPLE_W-1:0] : '0;
   assign sum_all   = acc_ff + prod_ff;
   assign pred_out  = sext_bits(asr32(sum_all, q_ff) + base_ff + resid_ff, bits_ff);

   // backward pass: last cell holds slot LAST - t_ff, adapted on its way to cell 0
   assign k_idx   = LAST - t_ff;
   assign stop    = sign_ff ? (err_ff[SAMPLE_W-1] || err_ff == '0) : !err_ff[SAMPLE_W-1];
   assign active  = (k_idx < n_ff) && !stop;
   assign d       = base_ff - hl;
   assign dneg    = d[SAMPLE_W-1];
   assign upd     = active && (d != '0);
   assign coef_adj = (sign_ff == dneg) ? coef_w[MAX_TAPS-1] + 16'd1
                                       : coef_w[MAX_TAPS-1] - 16'd1;
   assign mag     = (sign_ff == dneg) ? (SAMPLE_W'(0) - d) : d;
   assign shifted = asr32(mag, q_ff);
   assign step    = n_ff - k_idx;
   assign sub_full = shifted * step;
   assign err_next = upd ? err_ff - sub_full[SAMPLE_W-1:0] : err_ff;

   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.index = req_if.coef_index;
      ctrl.value = req_if.coef_value;
      head_hist  = hl;
      head_coef  = upd ? coef_adj : coef_w[MAX_TAPS-1];
      case (state_ff)
         ST_IDLE:  if (accept && !req_if.action) ctrl.op = CELL_LOAD;
         ST_MAC:   ctrl.op = CELL_FWD;
         ST_ADAPT: ctrl.op = CELL_BWD;
         ST_DONE: begin
            head_hist = samp_ff;
            if (done_fire) ctrl.op = CELL_SHIFT;
         end
         default: ;
      endcase
   end

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      slap_cell #(.SLOT(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_hist ((i == 0) ? head_hist : hist_w[(i + MAX_TAPS - 1) % MAX_TAPS]),
         .prev_coef ((i == 0) ? head_coef : coef_w[(i + MAX_TAPS - 1) % MAX_TAPS]),
         .next_hist (hist_w[(i + 1) % MAX_TAPS]),
         .next_coef (coef_w[(i + 1) % MAX_TAPS]),
         .hist      (hist_w[i]),
         .coef      (coef_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= TAP_RESET;
         q_ff         <= Q_RESET;
         bits_ff      <= BITS_RESET;
         pos_ff       <= '0;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            unique case (csr_index_type'(csr_if.index))
               CSR_TAP_COUNT:   tap_ff  <= csr_if.data[4:0];
               CSR_QUANT_SHIFT: q_ff    <= csr_if.data[3:0];
               CSR_SAMPLE_BITS: bits_ff <= csr_if.data;
               default: ;
            endcase
         end
         if (done_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_if.action) begin
                  resid_ff <= SAMPLE_W'(req_if.residual);
                  err_ff   <= SAMPLE_W'(req_if.residual);
                  sign_ff  <= !req_if.residual[31];
                  n_ff     <= n_cfg;
                  base_ff  <= hist_w[n_cfg];
                  acc_ff   <= round_term;
                  prod_ff  <= '0;
                  t_ff     <= '0;
                  if (req_if.frame_start || pos_ff == '0) begin
                     samp_ff  <= SAMPLE_W'(req_if.residual);
                     pos_ff   <= '0;
                     state_ff <= ST_DONE;
                  end else if (tap_ff == TAP_COPY) begin
                     samp_ff  <= SAMPLE_W'(req_if.residual);
                     state_ff <= ST_DONE;
                  end else if (tap_ff == TAP_FIRST_ORDER ||
                               pos_ff <= POS_W'(n_cfg)) begin
                     samp_ff  <= first_sum;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               prod_ff <= prod_in;
               acc_ff  <= sum_all;
               if (t_ff == LAST) begin
                  t_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  t_ff <= t_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               samp_ff  <= pred_out;
               state_ff <= ST_ADAPT;
            end
            ST_ADAPT: begin
               err_ff <= err_next;
               if (t_ff == LAST) begin
                  t_ff     <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  t_ff <= t_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (done_fire) begin
                  rsp_sample_ff <= samp_ff;
                  if (pos_ff != POS_SAT) pos_ff <= pos_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN || state_ff == ST_DONE) |-> t_ff == '0)
      else $error("ring rotation left incomplete");

   a_predict_past_warmup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && $past(state_ff == ST_IDLE)) |-> pos_ff > POS_W'(n_ff))
      else $error("prediction started during warm-up");

endmodule
`default_nettype wire

>>> sv/slap_cell.sv
`default_nettype none
module slap_cell #(
   parameter int unsigned SLOT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  slap_pkg::cell_ctrl_type ctrl,
   input  logic [31:0]             prev_hist,
   input  logic [15:0]             prev_coef,
   input  logic [31:0]             next_hist,
   input  logic [15:0]             next_coef,
   output logic [31:0]             hist,
   output logic [15:0]             coef
);
   import slap_pkg::*;

   logic [SAMPLE_W-1:0] hist_ff, hist_in;
   logic [COEF_W-1:0]   coef_ff, coef_in;

   always_comb begin
      hist_in = hist_ff;
      coef_in = coef_ff;
      case (ctrl.op)
         CELL_FWD: begin
            hist_in = next_hist;
            coef_in = next_coef;
         end
         CELL_BWD: begin
            hist_in = prev_hist;
            coef_in = prev_coef;
         end
         CELL_SHIFT: hist_in = prev_hist;
         CELL_LOAD: begin
            if (ctrl.index == SLOT_W'(SLOT)) coef_in = ctrl.value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         coef_ff <= '0;
      end else begin
         hist_ff <= hist_in;
         coef_ff <= coef_in;
      end
   end

   assign hist = hist_ff;
   assign coef = coef_ff;
endmodule
`default_nettype wire

>>> dv/slap_checker.sv
`timescale 1ns / 1ps
module slap_checker (
   input  logic clock,
   input  logic reset,
   slap_req_if.sink   req_mon,
   slap_rsp_if.sink   rsp_mon,
   slap_csr_if.sink   csr_mon,
   output int         fail_count,
   output int         pending_count
);
   import slap_pkg::*;

   logic [31:0] hist [32];
   logic [15:0] coefs [32];
   int unsigned pos;
   logic [4:0]  taps;
   logic [3:0]  qsh;
   logic [5:0]  sbits;
   logic [31:0] expected_samples [$];

   function automatic logic [31:0] extend(input logic [31:0] v, input logic [5:0] b);
      int unsigned w;
      logic [31:0] m;
      if (b >= 6'd32) return v;
      w = (b == 0) ? 1 : b;
      m = 32'd1 << (w - 1);
      v = v & ((32'd1 << w) - 1);
      return (v ^ m) - m;
   endfunction

   function automatic logic [31:0] shr(input logic [31:0] v, input logic [3:0] s);
      return $signed(v) >>> s;
   endfunction

   // one prediction step plus sign adaptation of the coefficient table
   function automatic logic [31:0] predict(input int unsigned n, input logic [31:0] e);
      logic [31:0] base, sum, o, d, mag;
      logic [31:0] c;
      logic pos_e, dneg;
      int k;
      base = hist[n];
      sum = 0;
      for (int j = 0; j < n; j++) begin
         c = {{16{coefs[j][15]}}, coefs[j]};
         sum += (hist[j] - base) * c;
      end
      if (qsh != 0) sum += 32'd1 << (qsh - 1);
      o = extend(shr(sum, qsh) + base + e, sbits);
      if (e != 0) begin
         pos_e = !e[31];
         for (k = n - 1; k >= 0; k--) begin
            if (pos_e ? (e[31] || e == 0) : !e[31]) break;
            d = base - hist[k];
            if (d != 0) begin
               dneg = d[31];
               if (pos_e) begin
                  coefs[k] = dneg ? coefs[k] + 16'd1 : coefs[k] - 16'd1;
                  mag = dneg ? -d : d;
               end else begin
                  coefs[k] = dneg ? coefs[k] - 16'd1 : coefs[k] + 16'd1;
                  mag = dneg ? d : -d;
               end
               e -= shr(mag, qsh) * (n - k);
            end
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] reconstruct(input logic fs, input logic [31:0] e);
      logic [31:0] s;
      int unsigned n;
      if (fs || pos == 0) begin
         s = e;
         pos = 0;
      end else if (taps == TAP_COPY) begin
         s = e;
      end else if (taps == TAP_FIRST_ORDER) begin
         s = extend(hist[0] + e, sbits);
      end else begin
         n = (taps > 31) ? 31 : taps;
         if (pos <= n) s = extend(hist[0] + e, sbits);
         else s = predict(n, e);
      end
      for (int k = 31; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = s;
      if (pos < 63) pos++;
      return s;
   endfunction

   assign pending_count = expected_samples.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            hist[i] = 0;
            coefs[i] = 0;
         end
         pos = 0;
         taps = TAP_RESET;
         qsh = Q_RESET;
         sbits = BITS_RESET;
         fail_count = 0;
         expected_samples.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_TAP_COUNT:   taps = csr_mon.data[4:0];
               CSR_QUANT_SHIFT: qsh = csr_mon.data[3:0];
               CSR_SAMPLE_BITS: sbits = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample %h", $time, rsp_mon.sample);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (want !== rsp_mon.sample) begin
                  $display("%0t: sample mismatch expected %h actual %h",
                           $time, want, rsp_mon.sample);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (!req_mon.action) coefs[req_mon.coef_index] = req_mon.coef_value;
            else expected_samples.push_back(
               reconstruct(req_mon.frame_start, req_mon.residual));
         end
      end
   end
endmodule

>>> dv/sign_lms_adaptive_predictor_core_tb.sv
`timescale 1ns / 1ps
module sign_lms_adaptive_predictor_core_tb;
   import slap_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending_count;
   int   cycle_count;
   int   item_count;
   bit   quiet_tail;
   bit   hold_rsp;

   slap_req_if req_if ();
   slap_rsp_if rsp_if ();
   slap_csr_if csr_if ();

   sign_lms_adaptive_predictor_core dut (
      .clock(clock), .reset(reset),
      .req_if(req_if.sink), .rsp_if(rsp_if.source), .csr_if(csr_if.sink)
   );

   slap_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_mon(req_if.sink), .rsp_mon(rsp_if.sink), .csr_mon(csr_if.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 2000000) begin
            $display("** sign_lms_adaptive_predictor_core: FAILED **");
            $finish;
         end
      end
   end

   // result side: random bursts of back pressure, or one long hold when hold_rsp is set
   initial begin
      int n;
      rsp_if.ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_if.ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_if.ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic act, input logic fs, input logic [4:0] idx,
                            input logic [15:0] cv, input logic [31:0] res);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.action <= act;
      req_if.frame_start <= fs;
      req_if.coef_index <= idx;
      req_if.coef_value <= cv;
      req_if.residual <= res;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      item_count++;
   endtask

   task automatic drain;
      req_if.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [5:0] val);
      csr_if.valid <= 1;
      csr_if.index <= idx;
      csr_if.data <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [4:0] t, input logic [3:0] q, input logic [5:0] b);
      write_csr(CSR_TAP_COUNT, {1'b0, t});
      write_csr(CSR_QUANT_SHIFT, {2'b0, q});
      write_csr(CSR_SAMPLE_BITS, b);
   endtask

   function automatic logic [31:0] rand_residual(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 64) - 32;
         default: return $urandom_range(0, 8000) - 4000;
      endcase
   endfunction

   // a frame: optional coefficient loads, then samples with random content
   task automatic run_frame(input int len, input int mode);
      for (int i = 0; i < 32; i++)
         if ($urandom_range(0, 3) == 0)
            send_item(1'b0, 1'($urandom_range(0, 1)), 5'(i),
                      16'($urandom_range(0, 1023) - 512), $urandom());
      for (int i = 0; i < len; i++)
         send_item(1'b1, (i == 0) || ($urandom_range(0, 60) == 0), 5'($urandom()),
                   16'($urandom()), rand_residual(mode));
   endtask

   initial begin
      int mode;
      reset = 1;
      req_if.valid = 0;
      req_if.action = 0;
      req_if.frame_start = 0;
      req_if.coef_index = 0;
      req_if.coef_value = 0;
      req_if.residual = 0;
      csr_if.valid = 0;
      csr_if.index = CSR_TAP_COUNT;
      csr_if.data = 0;
      quiet_tail = 0;
      hold_rsp = 0;
      item_count = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: residual with no frame begun, defaults, extremes
      send_item(1, 0, 0, 0, 32'h7fffffff);
      send_item(0, 1, 5'd0, 16'h7fff, 0);
      send_item(0, 0, 5'd31, 16'h8000, 0);
      send_item(0, 0, 5'd1, 16'hffff, 0);
      send_item(1, 0, 0, 0, 32'h80000000);
      send_item(1, 0, 5'h1f, 16'hffff, 32'hffffffff);
      send_item(1, 0, 0, 0, 32'd1);
      send_item(1, 0, 0, 0, 32'd0);
      send_item(1, 0, 0, 0, 32'h00001234);
      send_item(1, 0, 0, 0, 32'hffff0000);
      send_item(1, 1, 0, 0, 32'd5);
      drain();
      set_config(5'd0, 4'd1, 6'd2);
      send_item(1, 1, 0, 0, 32'hdeadbeef);
      send_item(1, 0, 0, 0, 32'h80000000);
      drain();
      set_config(5'd31, 4'd15, 6'd32);
      send_item(1, 1, 0, 0, 32'h7fffffff);
      send_item(1, 0, 0, 0, 32'd1);
      drain();
      set_config(5'd30, 4'd0, 6'd0);
      run_frame(40, 2);
      drain();
      set_config(5'd2, 4'd3, 6'd63);
      run_frame(10, 1);
      drain();

      // long receiver hold while sender keeps offering
      set_config(5'd1, 4'd4, 6'd20);
      hold_rsp = 1;
      run_frame(30, 2);
      drain();

      while (item_count < 1900) begin
         if (item_count > 1600) quiet_tail = 1;
         case ($urandom_range(0, 5))
            0: set_config(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                          6'($urandom_range(0, 63)));
            1: set_config(5'($urandom_range(1, 6)), 4'($urandom_range(1, 15)),
                          6'($urandom_range(2, 32)));
            2: set_config(5'd31, 4'($urandom_range(1, 15)), 6'($urandom_range(2, 32)));
            default: set_config(5'($urandom_range(1, 12)), 4'($urandom_range(4, 12)), 6'd16);
         endcase
         mode = $urandom_range(0, 2);
         run_frame($urandom_range(5, 50), mode);
         if ($urandom_range(0, 7) == 0)
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 5'($urandom()),
                      16'($urandom()), $urandom());
         drain();
      end
      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("** sign_lms_adaptive_predictor_core: PASSED **");
      end else begin
         $display("** sign_lms_adaptive_predictor_core: FAILED **");
      end
      $finish;
   end
endmodule
